// ----- src/line_protocol_record_parser_assert.svh -----
// ---------------------------------------------------------------------------
// Line protocol record parser assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef LINE_PROTOCOL_RECORD_PARSER_ASSERT_SVH
`define LINE_PROTOCOL_RECORD_PARSER_ASSERT_SVH

`ifndef SYNTH
`define LPRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line protocol parser check failed");
`define LPRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line protocol parser check failed");
`else
`define LPRP_ASSERT_NOW(label, clk, rst, ante, cons)
`define LPRP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/lprp_pkg.sv -----
// ---------------------------------------------------------------------------
// Line protocol record parser package
// Section and token kind codes, character codes, queue sizes and the result beat type.
// ---------------------------------------------------------------------------
package lprp_pkg;

   localparam logic [2:0] SEC_MEAS = 3'd0;
   localparam logic [2:0] SEC_TKEY = 3'd1;
   localparam logic [2:0] SEC_TVAL = 3'd2;
   localparam logic [2:0] SEC_FKEY = 3'd3;
   localparam logic [2:0] SEC_FVAL = 3'd4;
   localparam logic [2:0] SEC_TS   = 3'd5;

   localparam logic [2:0] KIND_STATUS = 3'd6;

   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [3:0]  token_index;
      logic [11:0] start_offset;
      logic [12:0] token_length;
      logic        record_status;
      logic [4:0]  tag_total;
      logic [4:0]  field_total;
      logic        last;
   } rsp_type;

endpackage

// ----- src/line_protocol_record_parser.sv -----
// ---------------------------------------------------------------------------
// Line protocol record parser
// Splits a line protocol record, one byte a beat, into tokens and a status.
// ---------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_data_byte, req_terminator           | in,  valid/ready
//  rsp     | rsp_token_kind .. rsp_last              | out, valid/ready
//
//  One beat a cycle while req_ready is high: every byte or terminator
//  updates the parser state in the cycle it is accepted and pushes 0, 1 or 2
//  result beats into a four-entry result queue, drained one beat a cycle
//  while rsp_ready is high. req_ready is high while the queue has room for
//  two beats. Reset is synchronous and clears the parser state and the
//  queue. A stalled rsp side fills the queue and then holds off req.
// ---------------------------------------------------------------------------
`include "line_protocol_record_parser_assert.svh"

module line_protocol_record_parser #(
   parameter int MAX_TAGS   = 16,
   parameter int MAX_FIELDS = 16,
   parameter int MAX_LINE   = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_terminator,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_kind,
   output logic [3:0]  rsp_token_index,
   output logic [11:0] rsp_start_offset,
   output logic [12:0] rsp_token_length,
   output logic        rsp_record_status,
   output logic [4:0]  rsp_tag_total,
   output logic [4:0]  rsp_field_total,
   output logic        rsp_last
);

   localparam int POS_W   = $clog2(MAX_LINE + 1);
   localparam int CNT_MAX = (MAX_TAGS > MAX_FIELDS) ? MAX_TAGS : MAX_FIELDS;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   function automatic logic [11:0] sat_offset(input logic [POS_W-1:0] v);
      logic [POS_W+11:0] w;
      w = {12'b0, v};
      return (w > (POS_W+12)'(4095)) ? 12'd4095 : w[11:0];
   endfunction

   function automatic logic [12:0] sat_length(input logic [POS_W-1:0] v);
      logic [POS_W+12:0] w;
      w = {13'b0, v};
      return (w > (POS_W+13)'(8191)) ? 13'd8191 : w[12:0];
   endfunction

   function automatic logic [4:0] sat_count(input logic [CNT_W-1:0] c);
      logic [CNT_W+4:0] w;
      w = {5'b0, c};
      return (w > (CNT_W+5)'(31)) ? 5'd31 : w[4:0];
   endfunction

   function automatic logic [3:0] slot_index(input logic [CNT_W-1:0] c);
      logic [CNT_W+3:0] w;
      w = {4'b0, c};
      return w[3:0];
   endfunction

   logic [2:0]       section_ff, section_in;
   logic             quote_ff, quote_in;
   logic             escape_ff, escape_in;
   logic             skip_ff, skip_in;
   logic             closed_ff, closed_in;
   logic             error_ff, error_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] trim_ff, trim_in;
   logic [CNT_W-1:0] tags_ff, tags_in;
   logic [CNT_W-1:0] fields_ff, fields_in;

   lprp_pkg::rsp_type queue_ff [lprp_pkg::QUEUE_DEPTH];
   logic [lprp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [lprp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lprp_pkg::QCNT_W-1:0] count_ff, count_in;

   logic              req_accept, rsp_accept;
   logic [1:0]        push_num, push_cnt;
   lprp_pkg::rsp_type beat0, beat1, token_beat, status_beat;
   logic              tok_emit, proceed, term_err, term_ok;
   logic [2:0]        tok_kind, term_sec;
   logic [3:0]        tok_index;
   logic [POS_W-1:0]  tok_end, p_plus;
   logic [CNT_W-1:0]  term_fields;
   logic [7:0]        b;

   assign req_ready  = count_ff <= lprp_pkg::QCNT_W'(lprp_pkg::QUEUE_DEPTH - 2);
   assign req_accept = req_valid & req_ready;
   assign rsp_valid  = count_ff != '0;
   assign rsp_accept = rsp_valid & rsp_ready;
   assign b          = req_data_byte;
   assign p_plus     = pos_ff + POS_W'(1);

   always_comb begin
      token_beat              = '0;
      token_beat.token_kind   = tok_kind;
      token_beat.token_index  = tok_index;
      token_beat.start_offset = sat_offset(start_ff);
      token_beat.token_length = sat_length(tok_end - start_ff);
   end

   always_comb begin
      status_beat               = '0;
      status_beat.token_kind    = lprp_pkg::KIND_STATUS;
      status_beat.record_status = ~term_ok;
      status_beat.tag_total     = sat_count(tags_ff);
      status_beat.field_total   = sat_count(term_fields);
      status_beat.last          = 1'b1;
   end

   always_comb begin
      section_in  = section_ff;
      quote_in    = quote_ff;
      escape_in   = escape_ff;
      skip_in     = skip_ff;
      closed_in   = closed_ff;
      error_in    = error_ff;
      pos_in      = pos_ff;
      start_in    = start_ff;
      trim_in     = trim_ff;
      tags_in     = tags_ff;
      fields_in   = fields_ff;
      tok_emit    = 1'b0;
      tok_kind    = lprp_pkg::SEC_MEAS;
      tok_index   = '0;
      tok_end     = pos_ff;
      proceed     = 1'b0;
      term_err    = error_ff | escape_ff | quote_ff;
      term_sec    = section_ff;
      term_fields = fields_ff;
      term_ok     = 1'b0;
      push_num    = 2'd0;
      beat0       = status_beat;
      beat1       = status_beat;

      if (req_terminator) begin
         if (!term_err && !closed_ff) begin
            if (section_ff == lprp_pkg::SEC_FVAL) begin
               if (pos_ff > start_ff) begin
                  tok_emit    = 1'b1;
                  tok_kind    = lprp_pkg::SEC_FVAL;
                  tok_index   = slot_index(fields_ff);
                  tok_end     = pos_ff;
                  term_fields = fields_ff + CNT_W'(1);
                  term_sec    = lprp_pkg::SEC_TS;
               end else begin
                  term_err = 1'b1;
               end
            end else if (section_ff == lprp_pkg::SEC_TS) begin
               if (trim_ff > start_ff) begin
                  tok_emit = 1'b1;
                  tok_kind = lprp_pkg::SEC_TS;
                  tok_end  = trim_ff;
               end
            end
         end
         term_ok = !term_err && term_sec == lprp_pkg::SEC_TS && term_fields != '0;
         if (tok_emit) begin
            beat0    = token_beat;
            push_num = 2'd2;
         end else begin
            push_num = 2'd1;
         end
         section_in = lprp_pkg::SEC_MEAS;
         quote_in   = 1'b0;
         escape_in  = 1'b0;
         skip_in    = 1'b0;
         closed_in  = 1'b0;
         error_in   = 1'b0;
         pos_in     = '0;
         start_in   = '0;
         trim_in    = '0;
         tags_in    = '0;
         fields_in  = '0;
      end else if (closed_ff || error_ff) begin
         proceed = 1'b0;
      end else if (pos_ff >= POS_W'(MAX_LINE)) begin
         error_in = 1'b1;
      end else begin
         pos_in  = p_plus;
         proceed = 1'b1;
         if (escape_ff) begin
            escape_in = 1'b0;
            proceed   = 1'b0;
            if (section_ff == lprp_pkg::SEC_TS && b != lprp_pkg::CHAR_SPACE) begin
               trim_in = p_plus;
            end
         end else if (skip_ff) begin
            if (b == lprp_pkg::CHAR_SPACE) begin
               start_in = p_plus;
               trim_in  = p_plus;
               proceed  = 1'b0;
            end else begin
               skip_in = 1'b0;
            end
         end
         if (proceed) begin
            if (b == lprp_pkg::CHAR_BACKSLASH) begin
               escape_in = 1'b1;
               if (section_ff == lprp_pkg::SEC_TS) begin
                  trim_in = p_plus;
               end
            end else begin
               tok_end = pos_ff;
               unique case (section_ff)
                  lprp_pkg::SEC_MEAS: begin
                     if (b == lprp_pkg::CHAR_COMMA || b == lprp_pkg::CHAR_SPACE) begin
                        if (pos_ff == start_ff) begin
                           error_in = 1'b1;
                        end else begin
                           tok_emit = 1'b1;
                           tok_kind = lprp_pkg::SEC_MEAS;
                           start_in = p_plus;
                           if (b == lprp_pkg::CHAR_COMMA) begin
                              section_in = lprp_pkg::SEC_TKEY;
                           end else begin
                              section_in = lprp_pkg::SEC_FKEY;
                              trim_in    = p_plus;
                              skip_in    = 1'b1;
                           end
                        end
                     end
                  end
                  lprp_pkg::SEC_TKEY: begin
                     if (b == lprp_pkg::CHAR_EQUALS) begin
                        if (tags_ff >= CNT_W'(MAX_TAGS) || pos_ff == start_ff) begin
                           error_in = 1'b1;
                        end else begin
                           tok_emit   = 1'b1;
                           tok_kind   = lprp_pkg::SEC_TKEY;
                           tok_index  = slot_index(tags_ff);
                           section_in = lprp_pkg::SEC_TVAL;
                           start_in   = p_plus;
                        end
                     end
                  end
                  lprp_pkg::SEC_TVAL: begin
                     if (b == lprp_pkg::CHAR_COMMA || b == lprp_pkg::CHAR_SPACE) begin
                        if (pos_ff == start_ff) begin
                           error_in = 1'b1;
                        end else begin
                           tok_emit  = 1'b1;
                           tok_kind  = lprp_pkg::SEC_TVAL;
                           tok_index = slot_index(tags_ff);
                           tags_in   = tags_ff + CNT_W'(1);
                           start_in  = p_plus;
                           if (b == lprp_pkg::CHAR_COMMA) begin
                              section_in = lprp_pkg::SEC_TKEY;
                           end else begin
                              section_in = lprp_pkg::SEC_FKEY;
                              trim_in    = p_plus;
                              skip_in    = 1'b1;
                           end
                        end
                     end
                  end
                  lprp_pkg::SEC_FKEY: begin
                     if (b == lprp_pkg::CHAR_EQUALS) begin
                        if (fields_ff >= CNT_W'(MAX_FIELDS) || pos_ff == start_ff) begin
                           error_in = 1'b1;
                        end else begin
                           tok_emit   = 1'b1;
                           tok_kind   = lprp_pkg::SEC_FKEY;
                           tok_index  = slot_index(fields_ff);
                           section_in = lprp_pkg::SEC_FVAL;
                           start_in   = p_plus;
                        end
                     end
                  end
                  lprp_pkg::SEC_FVAL: begin
                     if (b == lprp_pkg::CHAR_QUOTE) begin
                        quote_in = ~quote_ff;
                     end else if ((b == lprp_pkg::CHAR_COMMA || b == lprp_pkg::CHAR_SPACE)
                                  && !quote_ff) begin
                        if (pos_ff == start_ff) begin
                           error_in = 1'b1;
                        end else begin
                           tok_emit  = 1'b1;
                           tok_kind  = lprp_pkg::SEC_FVAL;
                           tok_index = slot_index(fields_ff);
                           fields_in = fields_ff + CNT_W'(1);
                           start_in  = p_plus;
                           if (b == lprp_pkg::CHAR_COMMA) begin
                              section_in = lprp_pkg::SEC_FKEY;
                           end else begin
                              section_in = lprp_pkg::SEC_TS;
                              trim_in    = p_plus;
                              skip_in    = 1'b1;
                           end
                        end
                     end else if (b == lprp_pkg::CHAR_LF || b == lprp_pkg::CHAR_CR) begin
                        if (quote_ff || pos_ff == start_ff) begin
                           error_in = 1'b1;
                        end else begin
                           tok_emit   = 1'b1;
                           tok_kind   = lprp_pkg::SEC_FVAL;
                           tok_index  = slot_index(fields_ff);
                           fields_in  = fields_ff + CNT_W'(1);
                           section_in = lprp_pkg::SEC_TS;
                           start_in   = pos_ff;
                           trim_in    = pos_ff;
                           closed_in  = 1'b1;
                        end
                     end
                  end
                  lprp_pkg::SEC_TS: begin
                     if (b == lprp_pkg::CHAR_LF || b == lprp_pkg::CHAR_CR) begin
                        if (trim_ff > start_ff) begin
                           tok_emit = 1'b1;
                           tok_kind = lprp_pkg::SEC_TS;
                           tok_end  = trim_ff;
                        end
                        closed_in = 1'b1;
                     end else if (b != lprp_pkg::CHAR_SPACE) begin
                        trim_in = p_plus;
                     end
                  end
                  default: begin
                     error_in = 1'b1;
                  end
               endcase
            end
         end
         if (tok_emit) begin
            beat0    = token_beat;
            push_num = 2'd1;
         end
      end
   end

   assign push_cnt    = req_accept ? push_num : 2'd0;
   assign wr_ptr_next = wr_ptr_ff + lprp_pkg::QPTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + lprp_pkg::QPTR_W'(push_cnt);
   assign rd_ptr_in   = rd_ptr_ff + lprp_pkg::QPTR_W'(rsp_accept);
   assign count_in    = count_ff + lprp_pkg::QCNT_W'(push_cnt)
                        - lprp_pkg::QCNT_W'(rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff <= lprp_pkg::SEC_MEAS;
         quote_ff   <= 1'b0;
         escape_ff  <= 1'b0;
         skip_ff    <= 1'b0;
         closed_ff  <= 1'b0;
         error_ff   <= 1'b0;
         pos_ff     <= '0;
         start_ff   <= '0;
         trim_ff    <= '0;
         tags_ff    <= '0;
         fields_ff  <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (req_accept) begin
            section_ff <= section_in;
            quote_ff   <= quote_in;
            escape_ff  <= escape_in;
            skip_ff    <= skip_in;
            closed_ff  <= closed_in;
            error_ff   <= error_in;
            pos_ff     <= pos_in;
            start_ff   <= start_in;
            trim_ff    <= trim_in;
            tags_ff    <= tags_in;
            fields_ff  <= fields_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= beat0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_next] <= beat1;
      end
   end

   assign rsp_token_kind    = queue_ff[rd_ptr_ff].token_kind;
   assign rsp_token_index   = queue_ff[rd_ptr_ff].token_index;
   assign rsp_start_offset  = queue_ff[rd_ptr_ff].start_offset;
   assign rsp_token_length  = queue_ff[rd_ptr_ff].token_length;
   assign rsp_record_status = queue_ff[rd_ptr_ff].record_status;
   assign rsp_tag_total     = queue_ff[rd_ptr_ff].tag_total;
   assign rsp_field_total   = queue_ff[rd_ptr_ff].field_total;
   assign rsp_last          = queue_ff[rd_ptr_ff].last;

   `LPRP_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= lprp_pkg::QCNT_W'(lprp_pkg::QUEUE_DEPTH))
   `LPRP_ASSERT_NOW(a_start_order, clock, reset, 1'b1, start_ff <= pos_ff && trim_ff <= pos_ff)
   `LPRP_ASSERT_NEXT(a_term_clears, clock, reset, req_accept && req_terminator, section_ff == lprp_pkg::SEC_MEAS && pos_ff == '0 && !error_ff)
   `LPRP_ASSERT_NEXT(a_err_holds, clock, reset, req_accept && !req_terminator && error_ff, $stable(pos_ff) && error_ff)

endmodule

// ----- test/line_protocol_record_parser_tb.sv -----
// ---------------------------------------------------------------------------
// Line protocol record parser testbench
// Streams directed, random, malformed and overlong records into the parser
// one byte a beat, predicts every token and status beat, and checks them in
// order while both sides idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module line_protocol_record_parser_tb;

   localparam int TAG_LIMIT   = 16;
   localparam int FIELD_LIMIT = 16;
   localparam int LINE_LIMIT  = 4096;
   localparam int BEAT_TARGET = 1200;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_terminator = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [3:0]  rsp_token_index;
   logic [11:0] rsp_start_offset;
   logic [12:0] rsp_token_length;
   logic        rsp_record_status;
   logic [4:0]  rsp_tag_total;
   logic [4:0]  rsp_field_total;
   logic        rsp_last;

   line_protocol_record_parser #(
      .MAX_TAGS   (TAG_LIMIT),
      .MAX_FIELDS (FIELD_LIMIT),
      .MAX_LINE   (LINE_LIMIT)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_terminator    (req_terminator),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_token_index   (rsp_token_index),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_token_length  (rsp_token_length),
      .rsp_record_status (rsp_record_status),
      .rsp_tag_total     (rsp_tag_total),
      .rsp_field_total   (rsp_field_total),
      .rsp_last          (rsp_last)
   );

   class parse_scoreboard;
      lprp_pkg::rsp_type expected_q[$];
      int          mismatch_count;
      int          token_count;
      int          record_count;
      int          rejected_count;
      logic [2:0]  section;
      bit          quote_open;
      bit          escape_pending;
      bit          skipping_spaces;
      bit          record_closed;
      bit          error_seen;
      int unsigned byte_pos;
      int unsigned token_start;
      int unsigned trim_end;
      int unsigned tags_done;
      int unsigned fields_done;

      function new();
         mismatch_count = 0;
         token_count = 0;
         record_count = 0;
         rejected_count = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         section = lprp_pkg::SEC_MEAS;
         quote_open = 0;
         escape_pending = 0;
         skipping_spaces = 0;
         record_closed = 0;
         error_seen = 0;
         byte_pos = 0;
         token_start = 0;
         trim_end = 0;
         tags_done = 0;
         fields_done = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void queue_token(logic [2:0] kind, int unsigned idx, int unsigned stop);
         lprp_pkg::rsp_type r;
         int unsigned len;
         r = '0;
         len = stop - token_start;
         r.token_kind = kind;
         r.token_index = idx[3:0];
         r.start_offset = (token_start > 4095) ? 12'd4095 : token_start[11:0];
         r.token_length = (len > 8191) ? 13'd8191 : len[12:0];
         expected_q.push_back(r);
      endfunction

      function void open_after_space(int unsigned p, logic [2:0] next);
         section = next;
         token_start = p + 1;
         trim_end = p + 1;
         skipping_spaces = 1;
      endfunction

      // returns 1 when the beat is consumed rather than ignored
      function bit parse_beat(logic [7:0] b, logic t);
         int unsigned       p;
         bit                bad;
         lprp_pkg::rsp_type r;
         if (t) begin
            bad = error_seen || escape_pending || quote_open;
            if (!bad && !record_closed) begin
               if (section == lprp_pkg::SEC_FVAL) begin
                  if (byte_pos > token_start) begin
                     queue_token(lprp_pkg::SEC_FVAL, fields_done, byte_pos);
                     fields_done++;
                     section = lprp_pkg::SEC_TS;
                  end else begin
                     bad = 1;
                  end
               end else if (section == lprp_pkg::SEC_TS && trim_end > token_start) begin
                  queue_token(lprp_pkg::SEC_TS, 0, trim_end);
               end
            end
            bad = bad || section != lprp_pkg::SEC_TS || fields_done == 0;
            r = '0;
            r.token_kind = lprp_pkg::KIND_STATUS;
            r.record_status = bad;
            r.tag_total = (tags_done > 31) ? 5'd31 : tags_done[4:0];
            r.field_total = (fields_done > 31) ? 5'd31 : fields_done[4:0];
            r.last = 1'b1;
            expected_q.push_back(r);
            record_count++;
            if (bad)
               rejected_count++;
            clear_parser();
            return 1;
         end
         if (record_closed || error_seen)
            return 0;
         if (byte_pos >= LINE_LIMIT) begin
            error_seen = 1;
            return 1;
         end
         p = byte_pos;
         byte_pos++;
         if (escape_pending) begin
            escape_pending = 0;
            if (section == lprp_pkg::SEC_TS && b != lprp_pkg::CHAR_SPACE)
               trim_end = p + 1;
            return 1;
         end
         if (skipping_spaces) begin
            if (b == lprp_pkg::CHAR_SPACE) begin
               token_start = p + 1;
               trim_end = p + 1;
               return 1;
            end
            skipping_spaces = 0;
         end
         if (b == lprp_pkg::CHAR_BACKSLASH) begin
            escape_pending = 1;
            if (section == lprp_pkg::SEC_TS)
               trim_end = p + 1;
            return 1;
         end
         case (section)
            lprp_pkg::SEC_MEAS: begin
               if (b == lprp_pkg::CHAR_COMMA || b == lprp_pkg::CHAR_SPACE) begin
                  if (p == token_start) begin
                     error_seen = 1;
                     return 1;
                  end
                  queue_token(lprp_pkg::SEC_MEAS, 0, p);
                  if (b == lprp_pkg::CHAR_COMMA) begin
                     section = lprp_pkg::SEC_TKEY;
                     token_start = p + 1;
                  end else begin
                     open_after_space(p, lprp_pkg::SEC_FKEY);
                  end
               end
            end
            lprp_pkg::SEC_TKEY: begin
               if (b == lprp_pkg::CHAR_EQUALS) begin
                  if (tags_done >= TAG_LIMIT || p == token_start) begin
                     error_seen = 1;
                     return 1;
                  end
                  queue_token(lprp_pkg::SEC_TKEY, tags_done, p);
                  section = lprp_pkg::SEC_TVAL;
                  token_start = p + 1;
               end
            end
            lprp_pkg::SEC_TVAL: begin
               if (b == lprp_pkg::CHAR_COMMA || b == lprp_pkg::CHAR_SPACE) begin
                  if (p == token_start) begin
                     error_seen = 1;
                     return 1;
                  end
                  queue_token(lprp_pkg::SEC_TVAL, tags_done, p);
                  tags_done++;
                  if (b == lprp_pkg::CHAR_COMMA) begin
                     section = lprp_pkg::SEC_TKEY;
                     token_start = p + 1;
                  end else begin
                     open_after_space(p, lprp_pkg::SEC_FKEY);
                  end
               end
            end
            lprp_pkg::SEC_FKEY: begin
               if (b == lprp_pkg::CHAR_EQUALS) begin
                  if (fields_done >= FIELD_LIMIT || p == token_start) begin
                     error_seen = 1;
                     return 1;
                  end
                  queue_token(lprp_pkg::SEC_FKEY, fields_done, p);
                  section = lprp_pkg::SEC_FVAL;
                  token_start = p + 1;
               end
            end
            lprp_pkg::SEC_FVAL: begin
               if (b == lprp_pkg::CHAR_QUOTE) begin
                  quote_open = !quote_open;
               end else if ((b == lprp_pkg::CHAR_COMMA || b == lprp_pkg::CHAR_SPACE)
                            && !quote_open) begin
                  if (p == token_start) begin
                     error_seen = 1;
                     return 1;
                  end
                  queue_token(lprp_pkg::SEC_FVAL, fields_done, p);
                  fields_done++;
                  if (b == lprp_pkg::CHAR_COMMA) begin
                     section = lprp_pkg::SEC_FKEY;
                     token_start = p + 1;
                  end else begin
                     open_after_space(p, lprp_pkg::SEC_TS);
                  end
               end else if (b == lprp_pkg::CHAR_LF || b == lprp_pkg::CHAR_CR) begin
                  if (quote_open || p == token_start) begin
                     error_seen = 1;
                     return 1;
                  end
                  queue_token(lprp_pkg::SEC_FVAL, fields_done, p);
                  fields_done++;
                  section = lprp_pkg::SEC_TS;
                  token_start = p;
                  trim_end = p;
                  record_closed = 1;
               end
            end
            lprp_pkg::SEC_TS: begin
               if (b == lprp_pkg::CHAR_LF || b == lprp_pkg::CHAR_CR) begin
                  if (trim_end > token_start)
                     queue_token(lprp_pkg::SEC_TS, 0, trim_end);
                  record_closed = 1;
               end else if (b != lprp_pkg::CHAR_SPACE) begin
                  trim_end = p + 1;
               end
            end
            default: error_seen = 1;
         endcase
         return 1;
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch on %s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_beat(lprp_pkg::rsp_type got);
         lprp_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result beat with nothing outstanding: kind %0d offset %0d",
                        got.token_kind, got.start_offset);
            return;
         end
         want = expected_q.pop_front();
         if (want.token_kind != lprp_pkg::KIND_STATUS)
            token_count++;
         compare_field("token_kind", want.token_kind, got.token_kind);
         compare_field("token_index", want.token_index, got.token_index);
         compare_field("start_offset", want.start_offset, got.start_offset);
         compare_field("token_length", want.token_length, got.token_length);
         compare_field("record_status", want.record_status, got.record_status);
         compare_field("tag_total", want.tag_total, got.tag_total);
         compare_field("field_total", want.field_total, got.field_total);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   parse_scoreboard sb;
   logic [7:0]      rec_bytes[$];
   int              counted_beats = 0;
   int              long_records = 0;
   int              cycle_count = 0;
   bit              sender_fast = 0;
   bit              rsp_fast = 0;
   bit              hold_request = 0;

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [7:0] special_char();
      case ($urandom_range(0, 6))
         0: return lprp_pkg::CHAR_COMMA;
         1: return lprp_pkg::CHAR_SPACE;
         2: return lprp_pkg::CHAR_EQUALS;
         3: return lprp_pkg::CHAR_QUOTE;
         4: return lprp_pkg::CHAR_LF;
         5: return lprp_pkg::CHAR_CR;
         default: return lprp_pkg::CHAR_BACKSLASH;
      endcase
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == lprp_pkg::CHAR_COMMA || c == lprp_pkg::CHAR_SPACE ||
             c == lprp_pkg::CHAR_EQUALS || c == lprp_pkg::CHAR_QUOTE ||
             c == lprp_pkg::CHAR_LF || c == lprp_pkg::CHAR_CR ||
             c == lprp_pkg::CHAR_BACKSLASH)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic void load_text(string s);
      rec_bytes.delete();
      for (int i = 0; i < s.len(); i++)
         rec_bytes.push_back(s[i]);
   endfunction

   function automatic void put_word(int n, bit value_mode);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            rec_bytes.push_back(lprp_pkg::CHAR_BACKSLASH);
            rec_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick == 1 && !value_mode) begin
            rec_bytes.push_back($urandom_range(0, 1) ? lprp_pkg::CHAR_LF : lprp_pkg::CHAR_CR);
         end else if (pick <= 3 && value_mode) begin
            rec_bytes.push_back(lprp_pkg::CHAR_QUOTE);
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 2))
                  0: rec_bytes.push_back(lprp_pkg::CHAR_SPACE);
                  1: rec_bytes.push_back(lprp_pkg::CHAR_COMMA);
                  default: rec_bytes.push_back(plain_char());
               endcase
            end
            rec_bytes.push_back(lprp_pkg::CHAR_QUOTE);
         end else begin
            rec_bytes.push_back(plain_char());
         end
      end
   endfunction

   function automatic void build_record();
      int mode;
      int count;
      int idx;
      rec_bytes.delete();
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         repeat ($urandom_range(1, 12))
            rec_bytes.push_back($urandom_range(0, 1) ? special_char()
                                                     : 8'($urandom_range(0, 255)));
         return;
      end
      put_word($urandom_range(1, 4), 0);
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 17) : $urandom_range(0, 3);
      repeat (count) begin
         rec_bytes.push_back(lprp_pkg::CHAR_COMMA);
         put_word($urandom_range(1, 3), 0);
         rec_bytes.push_back(lprp_pkg::CHAR_EQUALS);
         put_word($urandom_range(1, 3), 0);
      end
      repeat ($urandom_range(1, 3))
         rec_bytes.push_back(lprp_pkg::CHAR_SPACE);
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 17) : $urandom_range(1, 3);
      for (int i = 0; i < count; i++) begin
         if (i > 0)
            rec_bytes.push_back(lprp_pkg::CHAR_COMMA);
         put_word($urandom_range(1, 3), 0);
         rec_bytes.push_back(lprp_pkg::CHAR_EQUALS);
         put_word($urandom_range(1, 3), 1);
      end
      case ($urandom_range(0, 5))
         0: rec_bytes.push_back($urandom_range(0, 1) ? lprp_pkg::CHAR_LF : lprp_pkg::CHAR_CR);
         1: ;
         2: repeat ($urandom_range(1, 3)) rec_bytes.push_back(lprp_pkg::CHAR_SPACE);
         default: begin
            repeat ($urandom_range(1, 3))
               rec_bytes.push_back(lprp_pkg::CHAR_SPACE);
            repeat ($urandom_range(1, 10))
               rec_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 5) == 0)
               put_word(1, 0);
            repeat ($urandom_range(0, 2))
               rec_bytes.push_back(lprp_pkg::CHAR_SPACE);
            if ($urandom_range(0, 1))
               rec_bytes.push_back($urandom_range(0, 1) ? lprp_pkg::CHAR_LF
                                                        : lprp_pkg::CHAR_CR);
         end
      endcase
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3))
            rec_bytes.push_back(8'($urandom_range(0, 255)));
      if (mode >= 8) begin
         idx = $urandom_range(0, rec_bytes.size() - 1);
         case ($urandom_range(0, 2))
            0: rec_bytes[idx] = special_char();
            1: rec_bytes.delete(idx);
            default: while (rec_bytes.size() > idx) void'(rec_bytes.pop_back());
         endcase
      end
   endfunction

   function automatic void load_tail(bit overrun);
      rec_bytes.push_back(lprp_pkg::CHAR_COMMA);
      rec_bytes.push_back(8'h67);
      rec_bytes.push_back(lprp_pkg::CHAR_EQUALS);
      rec_bytes.push_back(plain_char());
      if (overrun)
         rec_bytes.push_back(plain_char());
   endfunction

   // the record runs up to the line limit; the overrun variant adds a byte past it
   function automatic void build_long(bit overrun);
      load_text("m f=");
      repeat (4088)
         rec_bytes.push_back(plain_char());
      load_tail(overrun);
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic t);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_terminator <= t;
      do @(posedge clock); while (!req_ready);
      if (sb.parse_beat(b, t))
         counted_beats++;
   endtask

   task automatic send_record();
      foreach (rec_bytes[i])
         send_beat(rec_bytes[i], 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   initial begin
      int stall;
      lprp_pkg::rsp_type got;
      wait (reset == 1'b0);
      forever begin
         stall = rsp_fast ? 0 : $urandom_range(0, 19);
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.token_kind = rsp_token_kind;
         got.token_index = rsp_token_index;
         got.start_offset = rsp_start_offset;
         got.token_length = rsp_token_length;
         got.record_status = rsp_record_status;
         got.tag_total = rsp_tag_total;
         got.field_total = rsp_field_total;
         got.last = rsp_last;
         sb.check_beat(got);
      end
   end

   initial begin
      int rec_no;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      load_text("m,t=v f=\"a\" 9 \n");
      rec_bytes.push_back(8'hFF);
      send_record();
      load_text(" f=\\");
      rec_bytes.push_front(8'h00);
      send_record();

      rec_no = 0;
      while (counted_beats < BEAT_TARGET) begin
         if (rec_no == 25) begin
            hold_request = 1;
            sender_fast = 1;
         end
         if (rec_no == 31)
            sender_fast = 0;
         if (rec_no == 50) begin
            sender_fast = 1;
            rsp_fast = 1;
         end
         if (rec_no == 60) begin
            sender_fast = 0;
            rsp_fast = 0;
         end
         build_record();
         send_record();
         rec_no++;
      end

      sender_fast = 1;
      rsp_fast = 1;
      for (int i = 0; i < 2; i++) begin
         build_long(i == 1);
         send_record();
         long_records++;
      end
      sender_fast = 0;
      rsp_fast = 0;

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d records (%0d rejected, %0d at the line limit), %0d tokens",
               sb.record_count, sb.rejected_count, long_records, sb.token_count);
      $display("%0d consumed input beats, %0d mismatches", counted_beats, sb.mismatch_count);
      if (sb.mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
